@@ rtl/modular_exponentiation_top_macros.svh @@
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// same-cycle check, clocked on clk, off during reset
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, clocked on clk, off during reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/modexp_pkg.sv @@
package modexp_pkg;

    localparam int MOD_W   = 31;
    localparam int FIELD_W = 63;

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    localparam int MUL_CNT_W = $clog2(MOD_W);
    localparam int RED_CNT_W = $clog2(FIELD_W);

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] value;
    } mm_rsp_t;

endpackage

@@ rtl/modexp_reduce.sv @@
`include "modular_exponentiation_top_macros.svh"

module modexp_reduce import modexp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FIELD_W-1:0] value,
    input  logic [MOD_W-1:0]   m,
    output mm_rsp_t            rsp
);

    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [RED_CNT_W-1:0] cnt_reg;
    logic [RED_CNT_W-1:0] cnt_next;
    logic [FIELD_W-1:0]   val_reg;
    logic [FIELD_W-1:0]   val_next;
    logic [MOD_W-1:0]     r_reg;
    logic [MOD_W-1:0]     r_next;
    logic [MOD_W:0]       shifted;
    logic [MOD_W:0]       trial;

    // one bit of the base per cycle, msb first
    assign shifted = {r_reg, val_reg[FIELD_W-1]};
    assign trial   = shifted - {1'b0, m};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        r_next    = r_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = RED_CNT_W'(FIELD_W - 1);
            val_next = value;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            r_next   = (shifted >= {1'b0, m}) ? trial[MOD_W-1:0] : shifted[MOD_W-1:0];
            val_next = {val_reg[FIELD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        r_reg   <= r_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

    `MODEXP_ASSERT_NOW(a_red_partial_below_mod, run_reg, r_reg < m, "reduce partial out of range")

endmodule

@@ rtl/modexp_mulmod.sv @@
`include "modular_exponentiation_top_macros.svh"

module modexp_mulmod import modexp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MOD_W-1:0] a,
    input  logic [MOD_W-1:0] b,
    input  logic [MOD_W-1:0] m,
    output mm_rsp_t          rsp
);

    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_CNT_W-1:0] cnt_next;
    logic [MOD_W-1:0]     b_reg;
    logic [MOD_W-1:0]     b_next;
    logic [MOD_W-1:0]     r_reg;
    logic [MOD_W-1:0]     r_next;
    logic [MOD_W:0]       dbl;
    logic [MOD_W-1:0]     dbl_red;
    logic [MOD_W:0]       sum;
    logic [MOD_W-1:0]     sum_red;

    // interleaved shift-add, one multiplier bit per cycle, msb first
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? MOD_W'(dbl - {1'b0, m}) : dbl[MOD_W-1:0];
        sum     = {1'b0, dbl_red} + (b_reg[MOD_W-1] ? {1'b0, a} : '0);
        sum_red = (sum >= {1'b0, m}) ? MOD_W'(sum - {1'b0, m}) : sum[MOD_W-1:0];
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = MUL_CNT_W'(MOD_W - 1);
            b_next   = b;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            r_next   = sum_red;
            b_next   = {b_reg[MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = r_reg;

    `MODEXP_ASSERT_NOW(a_mul_partial_below_mod, run_reg, r_reg < m, "product partial out of range")

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// An item is taken when start is high and busy is low; busy stays high until
// the result goes out. The result appears on power_result for exactly one
// cycle with done high, and the receiver cannot stall it, so it must take it
// then. The base is first reduced one bit per cycle, then for each exponent bit
// up to the highest set one the square and the conditional multiply run side
// by side on two bit-serial multipliers of 31 steps each. Busy drops in the
// same cycle as the result goes out, so the next item can be taken while the
// result is out; a modulus below 2 returns 0. The modulus register is written
// by cfg_we/cfg_wdata and must only change while busy is low.
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top import modexp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [MOD_W-1:0]   cfg_wdata,
    input  logic               start,
    input  logic [FIELD_W-1:0] base,
    input  logic [FIELD_W-1:0] exponent,
    output logic               busy,
    output logic               done,
    output logic [MOD_W-1:0]   power_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RED   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_MUL   = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [MOD_W-1:0]   modulus_reg;
    logic [MOD_W-1:0]   m_reg;
    logic [MOD_W-1:0]   m_next;
    logic [FIELD_W-1:0] e_reg;
    logic [FIELD_W-1:0] e_next;
    logic [MOD_W-1:0]   acc_reg;
    logic [MOD_W-1:0]   acc_next;
    logic [MOD_W-1:0]   sq_reg;
    logic [MOD_W-1:0]   sq_next;
    logic               done_reg;
    logic               done_next;
    logic [MOD_W-1:0]   result_reg;
    logic [MOD_W-1:0]   result_next;
    logic               red_start;
    logic               mm_start;
    mm_rsp_t            red_rsp;
    mm_rsp_t            acc_rsp;
    mm_rsp_t            sq_rsp;

    modexp_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .value (base),
        .m     (m_reg),
        .rsp   (red_rsp)
    );

    modexp_mulmod u_mul_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (acc_reg),
        .b     (sq_reg),
        .m     (m_reg),
        .rsp   (acc_rsp)
    );

    modexp_mulmod u_mul_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (sq_reg),
        .b     (sq_reg),
        .m     (m_reg),
        .rsp   (sq_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        red_start   = 1'b0;
        mm_start    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_next = modulus_reg;
                    e_next = exponent;
                    if (modulus_reg < MOD_W'(2))
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (red_rsp.done)
                begin
                    sq_next    = red_rsp.value;
                    acc_next   = MOD_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (e_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = acc_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (sq_rsp.done)
                begin
                    if (e_reg[0])
                    begin
                        acc_next = acc_rsp.value;
                    end
                    sq_next    = sq_rsp.value;
                    e_next     = {1'b0, e_reg[FIELD_W-1:1]};
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            modulus_reg <= MOD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign power_result = result_reg;

    `MODEXP_ASSERT_NEXT(a_busy_after_start, start && !busy && (modulus_reg >= MOD_W'(2)),
        busy, "no busy after transfer")
    `MODEXP_ASSERT_NOW(a_result_in_range, done && (m_reg >= MOD_W'(2)),
        power_result < m_reg, "result not reduced")
    `MODEXP_ASSERT_NOW(a_mul_needs_bits, state_reg == S_MUL, e_reg != '0, "multiply with empty exponent")
    `MODEXP_ASSERT_NOW(a_units_in_step, sq_rsp.done,
        acc_rsp.done && (state_reg == S_MUL), "multipliers out of step")

endmodule

@@ verif/tb_modular_exponentiation_top.sv @@
`timescale 1ns / 1ps

module tb_modular_exponentiation_top;
    import modexp_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 2200;

    class power_board;
        bit [MOD_W-1:0] modulus;
        bit [MOD_W-1:0] pending_powers[$];
        int unsigned    fails;
        int unsigned    checked;

        function new();
            modulus = MOD_RESET;
            fails   = 0;
            checked = 0;
        endfunction

        function bit [MOD_W-1:0] predict_power(bit [FIELD_W-1:0] b, bit [FIELD_W-1:0] e);
            bit [63:0]        m;
            bit [63:0]        acc;
            bit [63:0]        sq;
            bit [FIELD_W-1:0] rest;
            m = 64'(modulus);
            if (m < 64'd2)
                return '0;
            acc  = 64'd1;
            sq   = 64'(b) % m;
            rest = e;
            while (rest != '0)
            begin
                if (rest[0])
                    acc = (acc * sq) % m;
                sq   = (sq * sq) % m;
                rest = rest >> 1;
            end
            return acc[MOD_W-1:0];
        endfunction

        function void note_operands(bit [FIELD_W-1:0] b, bit [FIELD_W-1:0] e);
            pending_powers = {pending_powers, predict_power(b, e)};
        endfunction

        function void check_power(bit [MOD_W-1:0] actual);
            bit [MOD_W-1:0] want;
            if (pending_powers.size() == 0)
            begin
                $error("power_result with no transfer pending: expected none, actual %0d",
                       actual);
                fails++;
            end
            else
            begin
                want = pending_powers.pop_front();
                checked++;
                if (want != actual)
                begin
                    $error("power_result mismatch: expected %0d, actual %0d", want, actual);
                    fails++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [MOD_W-1:0]   cfg_wdata;
    logic               start;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic               busy;
    logic               done;
    logic [MOD_W-1:0]   power_result;

    power_board  board = new();
    int unsigned items_sent;
    int unsigned modulus_writes;
    int unsigned wide_exponents;
    int unsigned idle_cycles = 0;

    modular_exponentiation_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .base         (base),
        .exponent     (exponent),
        .busy         (busy),
        .done         (done),
        .power_result (power_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_power(power_result);
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic bit [FIELD_W-1:0] rand_field();
        bit [63:0] w;
        w = {$urandom, $urandom};
        return w[FIELD_W-1:0];
    endfunction

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(16, 120);
    endfunction

    function automatic bit [FIELD_W-1:0] pick_exponent();
        int unsigned r;
        int          len;
        r = $urandom_range(0, 99);
        if (r < 55)
            len = $urandom_range(0, 8);
        else if (r < 80)
            len = $urandom_range(9, 20);
        else if (r < 94)
            len = $urandom_range(21, 40);
        else
        begin
            wide_exponents++;
            return rand_field();
        end
        if (len == 0)
            return '0;
        return (rand_field() >> (FIELD_W - len)) | (FIELD_W'(1) << (len - 1));
    endfunction

    function automatic bit [FIELD_W-1:0] pick_base(bit [MOD_W-1:0] m);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return rand_field();
        else if (r < 55)
            return (m == '0) ? rand_field() : rand_field() % FIELD_W'(m);
        else if (r < 70)
            return FIELD_W'($urandom_range(0, 15));
        else if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return FIELD_W'(1);
                2:       return FIELD_W'(m) - FIELD_W'(1);
                3:       return FIELD_W'(m);
                default: return '1;
            endcase
        end
        return rand_field() >> $urandom_range(0, FIELD_W - 1);
    endfunction

    task automatic send_operands(input bit [FIELD_W-1:0] b, input bit [FIELD_W-1:0] e,
                                 input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        base     <= b;
        exponent <= e;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_operands(b, e);
        items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending_powers.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_modulus(input bit [MOD_W-1:0] m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we        <= 1'b0;
        board.modulus  = m;
        modulus_writes++;
    endtask

    task automatic send_directed(input bit [FIELD_W-1:0] b, input bit [FIELD_W-1:0] e);
        send_operands(b, e, pick_gap(1'b0));
    endtask

    initial
    begin
        bit [MOD_W-1:0] m;
        bit             steady;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        start          = 1'b0;
        base           = '0;
        exponent       = '0;
        items_sent     = 0;
        modulus_writes = 0;
        wide_exponents = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus, exponent zero and field extremes
        send_directed('0, '0);
        send_directed('0, '1);
        send_directed('1, '0);
        send_directed('1, '1);
        send_directed(FIELD_W'(1), '1);
        send_directed(FIELD_W'(MOD_RESET), FIELD_W'(5));
        send_directed(FIELD_W'(MOD_RESET) - 1, '1);
        send_directed(FIELD_W'(MOD_RESET) - 1, '1 - FIELD_W'(1));
        send_directed(FIELD_W'(2), FIELD_W'(1));
        send_directed(FIELD_W'(3), FIELD_W'(2));
        send_directed(FIELD_W'(7), FIELD_W'(1) << (FIELD_W - 1));
        send_directed(FIELD_W'(123456789), 63'h5555_5555_5555_5555);
        send_directed(63'h2aaa_aaaa_aaaa_aaaa, 63'h2aaa_aaaa_aaaa_aaaa);

        write_modulus(31'h7fff_ffff);
        send_directed('1, '1);
        send_directed(FIELD_W'(31'h7fff_ffff) + 1, FIELD_W'(2));
        send_directed(FIELD_W'(31'h7fff_fffe), FIELD_W'(3));

        write_modulus(31'd2);
        send_directed(FIELD_W'(3), '1);
        send_directed(FIELD_W'(4), FIELD_W'(1));

        // modulus one and modulus zero both give zero
        write_modulus(31'd1);
        send_directed(FIELD_W'(5), '0);
        send_directed('1, '1);
        write_modulus('0);
        send_directed('0, '0);
        send_directed(FIELD_W'(9), FIELD_W'(3));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       m = 31'h7fff_ffff;
                1:       m = 31'd2;
                2:       m = 31'd3;
                3:       m = MOD_RESET;
                4:       m = 31'h4000_0000;
                5:       m = 31'h7fff_fffe;
                6:       m = MOD_W'($urandom_range(2, 1000));
                default: m = MOD_W'($urandom_range(2, 32'h7fff_ffff));
            endcase
            write_modulus(m);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_operands(pick_base(m), pick_exponent(), pick_gap(steady));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending_powers.size() != 0)
        begin
            $error("power_result missing: expected %0d more, actual 0",
                   board.pending_powers.size());
            board.fails++;
        end

        $display("sent %0d operand pairs across %0d modulus writes, %0d with full-width exponents",
                 items_sent, modulus_writes, wide_exponents);
        $display("compared %0d powers, %0d failures", board.checked, board.fails);
        if (board.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
